[design/qrs_pkg.sv]
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int RAD_W    = 50;   // discriminant shifted up by 16
    localparam int SQ_W     = 25;   // square root width
    localparam int SREM_W   = 27;   // square root remainder width
    localparam int NUM_W    = 27;   // numerator -B*256 +/- S
    localparam int DVD_W    = 36;   // divider dividend width
    localparam int DVS_W    = 18;   // divider divisor width
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = 2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic                     azero;
        logic                     dpos;
        logic                     dzero;
    } info_t;

    typedef struct packed {
        info_t             info;
        logic [SQ_W-1:0]   s;
    } mid_t;

    typedef struct packed {
        logic [1:0]         count;
        logic signed [31:0] rp;
        logic signed [31:0] rm;
        logic [1:0]         status;
    } res_t;

endpackage

[design/qrs_front.sv]
// Front pipeline: discriminant and pipelined square root.
module qrs_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [15:0]     coef_a,
    input  logic signed [15:0]     coef_b,
    input  logic signed [15:0]     coef_c,
    input  logic                   q_full,
    output logic                   q_push,
    output qrs_pkg::mid_t          q_data
);

    localparam int NS = qrs_pkg::SQ_W;

    logic                adv;
    logic                v0_reg, v1_reg;
    logic signed [15:0]  a0_reg, b0_reg, c0_reg;
    logic signed [15:0]  a1_reg, b1_reg;
    logic signed [31:0]  bb1_reg, ac1_reg;
    logic signed [34:0]  d_next;

    logic                   sv_valid_reg [0:NS];
    qrs_pkg::info_t         si_reg       [0:NS];
    logic [qrs_pkg::RAD_W-1:0]  sv_reg   [0:NS];
    logic [qrs_pkg::SREM_W-1:0] sr_reg   [0:NS];
    logic [NS-1:0]              sq_reg   [0:NS];

    assign adv      = !q_full;
    assign in_ready = adv;

    assign d_next = 35'(bb1_reg) - (35'(ac1_reg) <<< 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg          <= 1'b0;
            v1_reg          <= 1'b0;
            sv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg          <= in_valid;
            v1_reg          <= v0_reg;
            sv_valid_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a0_reg  <= coef_a;
            b0_reg  <= coef_b;
            c0_reg  <= coef_c;
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
            si_reg[0].a     <= a1_reg;
            si_reg[0].b     <= b1_reg;
            si_reg[0].azero <= (a1_reg == 16'sd0);
            si_reg[0].dpos  <= !d_next[34] && (d_next != 35'sd0);
            si_reg[0].dzero <= (d_next == 35'sd0);
            sv_reg[0] <= (!d_next[34] && (d_next != 35'sd0)) ?
                         {d_next[33:0], 16'd0} : '0;
            sr_reg[0] <= '0;
            sq_reg[0] <= '0;
        end
    end

    // one root bit per stage
    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_sqrt
            logic [qrs_pkg::SREM_W+1:0] cur;
            logic [qrs_pkg::SREM_W+1:0] trial;
            logic                       ge;
            logic [qrs_pkg::SREM_W+1:0] diff;

            assign cur   = {sr_reg[k], sv_reg[k][qrs_pkg::RAD_W-1 -: 2]};
            assign trial = {2'b00, sq_reg[k], 2'b01};
            assign ge    = (cur >= trial);
            assign diff  = ge ? (cur - trial) : cur;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_valid_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    sv_valid_reg[k+1] <= sv_valid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    si_reg[k+1] <= si_reg[k];
                    sv_reg[k+1] <= sv_reg[k] << 2;
                    sr_reg[k+1] <= diff[qrs_pkg::SREM_W-1:0];
                    sq_reg[k+1] <= {sq_reg[k][NS-2:0], ge};
                end
            end
        end
    endgenerate

    assign q_push      = adv && sv_valid_reg[NS];
    assign q_data.info = si_reg[NS];
    assign q_data.s    = sq_reg[NS];

endmodule

[design/qrs_queue.sv]
// Small queue between the front and back pipelines.
module qrs_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  qrs_pkg::mid_t push_data,
    output logic          full,
    output logic          not_empty,
    input  logic          pop,
    output qrs_pkg::mid_t pop_data
);

    qrs_pkg::mid_t                mem_reg [0:qrs_pkg::Q_DEPTH-1];
    logic [qrs_pkg::Q_AW-1:0]     wp_reg, rp_reg;
    logic [qrs_pkg::Q_AW:0]       cnt_reg;

    assign full      = (cnt_reg == (qrs_pkg::Q_AW+1)'(qrs_pkg::Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

endmodule

[design/qrs_back.sv]
// Back pipeline: two rounding dividers, saturation and output buffer.
module qrs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  qrs_pkg::mid_t      q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         root_count,
    output logic signed [31:0] root_plus,
    output logic signed [31:0] root_minus,
    output logic [1:0]         status
);

    localparam int ND = qrs_pkg::DVD_W;

    logic adv;
    logic [1:0] ocnt_reg;
    logic       owp_reg, orp_reg;
    qrs_pkg::res_t oent_reg [0:1];

    logic                       dvalid_reg [0:ND];
    qrs_pkg::info_t             di_reg     [0:ND];
    logic                       dneg_reg   [0:ND][0:1];
    logic [ND-1:0]              dx_reg     [0:ND][0:1];
    logic [qrs_pkg::DVS_W-1:0]  dr_reg     [0:ND][0:1];
    logic [ND-1:0]              dq_reg     [0:ND][0:1];
    logic [qrs_pkg::DVS_W-1:0]  dy_reg     [0:ND];

    logic signed [qrs_pkg::NUM_W-1:0] nb, sx;
    logic signed [qrs_pkg::NUM_W-1:0] num [0:1];
    logic [16:0] ua;

    assign adv   = (ocnt_reg != 2'd2);
    assign q_pop = adv && q_not_empty;

    assign nb = -($signed({{3{q_data.info.b[15]}}, q_data.info.b, 8'd0}));
    assign sx = $signed({2'b00, q_data.s});
    assign num[0] = nb + sx;
    assign num[1] = nb - sx;
    assign ua = q_data.info.a[15] ? 17'(-$signed({q_data.info.a[15], q_data.info.a}))
                                  : {1'b0, q_data.info.a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dvalid_reg[0] <= q_not_empty;
        end
    end

    genvar j, k;
    generate
        for (j = 0; j < 2; j++)
        begin : g_load
            logic [qrs_pkg::NUM_W-1:0] un;
            assign un = num[j][qrs_pkg::NUM_W-1] ? qrs_pkg::NUM_W'(-num[j])
                                                  : qrs_pkg::NUM_W'(num[j]);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dneg_reg[0][j] <= num[j][qrs_pkg::NUM_W-1] ^ q_data.info.a[15];
                    // dividend 2*|N*128| + |A|
                    dx_reg[0][j]   <= {1'b0, un, 8'd0} + ND'(ua);
                    dr_reg[0][j]   <= '0;
                    dq_reg[0][j]   <= '0;
                end
            end
        end

        for (k = 0; k < ND; k++)
        begin : g_div
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dvalid_reg[k+1] <= 1'b0;
                end
                else if (adv)
                begin
                    dvalid_reg[k+1] <= dvalid_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    di_reg[k+1] <= di_reg[k];
                    dy_reg[k+1] <= dy_reg[k];
                end
            end

            for (j = 0; j < 2; j++)
            begin : g_lane
                logic [qrs_pkg::DVS_W:0] cur;
                logic                    ge;
                logic [qrs_pkg::DVS_W:0] diff;

                assign cur  = {dr_reg[k][j], dx_reg[k][j][ND-1]};
                assign ge   = (cur >= {1'b0, dy_reg[k]});
                assign diff = ge ? (cur - {1'b0, dy_reg[k]}) : cur;

                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        dneg_reg[k+1][j] <= dneg_reg[k][j];
                        dx_reg[k+1][j]   <= dx_reg[k][j] << 1;
                        dr_reg[k+1][j]   <= diff[qrs_pkg::DVS_W-1:0];
                        dq_reg[k+1][j]   <= {dq_reg[k][j][ND-2:0], ge};
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            di_reg[0] <= q_data.info;
            dy_reg[0] <= {ua, 1'b0};
        end
    end

    // sign, saturation and classification at the pipeline end
    logic [31:0]   rv   [0:1];
    logic          rsat [0:1];
    qrs_pkg::res_t res;
    qrs_pkg::info_t fi;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (dneg_reg[ND][i])
            begin
                rsat[i] = (dq_reg[ND][i] > ND'(33'h0_8000_0000));
                rv[i]   = rsat[i] ? 32'h8000_0000 : 32'(-dq_reg[ND][i]);
            end
            else
            begin
                rsat[i] = (dq_reg[ND][i] > ND'(32'h7FFF_FFFF));
                rv[i]   = rsat[i] ? 32'h7FFF_FFFF : dq_reg[ND][i][31:0];
            end
        end
        fi = di_reg[ND];
        res.count  = 2'd0;
        res.rp     = '0;
        res.rm     = '0;
        res.status = qrs_pkg::ST_OK;
        if (fi.azero)
        begin
            res.status = qrs_pkg::ST_AZERO;
        end
        else if (fi.dpos)
        begin
            res.count = 2'd2;
            res.rp    = rv[0];
            res.rm    = rv[1];
            if (rsat[0] || rsat[1])
            begin
                res.status = qrs_pkg::ST_SAT;
            end
        end
        else if (fi.dzero)
        begin
            res.count = 2'd1;
            res.rp    = rv[0];
            if (rsat[0])
            begin
                res.status = qrs_pkg::ST_SAT;
            end
        end
    end

    logic opush, opop;
    assign opush = adv && dvalid_reg[ND];
    assign opop  = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            owp_reg  <= 1'b0;
            orp_reg  <= 1'b0;
        end
        else
        begin
            if (opush)
            begin
                owp_reg <= !owp_reg;
            end
            if (opop)
            begin
                orp_reg <= !orp_reg;
            end
            if (opush && !opop)
            begin
                ocnt_reg <= ocnt_reg + 2'd1;
            end
            else if (opop && !opush)
            begin
                ocnt_reg <= ocnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            oent_reg[owp_reg] <= res;
        end
    end

    assign out_valid  = (ocnt_reg != 2'd0);
    assign root_count = oent_reg[orp_reg].count;
    assign root_plus  = oent_reg[orp_reg].rp;
    assign root_minus = oent_reg[orp_reg].rm;
    assign status     = oent_reg[orp_reg].status;

endmodule

[design/quadratic_root_solver_unit.sv]
// Quadratic root solver top level: front pipeline, queue, back pipeline.
// Pipeline: 67 register stages: 3 discriminant, 25 square-root, queue, 37 divider, output buffer.
// Throughput: one item per cycle; each pipeline stalls as a whole when its downstream buffer is full.
// Reset: rst_n clears all valid bits and queue pointers; no item survives.
module quadratic_root_solver_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         root_count,
    output logic signed [31:0] root_plus,
    output logic signed [31:0] root_minus,
    output logic [1:0]         status
);

    logic          q_full, q_push, q_not_empty, q_pop;
    qrs_pkg::mid_t q_in, q_out;

    qrs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .coef_a   (coef_a),
        .coef_b   (coef_b),
        .coef_c   (coef_c),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    qrs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    qrs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .root_count  (root_count),
        .root_plus   (root_plus),
        .root_minus  (root_minus),
        .status      (status)
    );

endmodule

[tb/sv/qrs_checker.sv]
// Checker for the quadratic root solver: predicts each root item and compares results.
module qrs_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] coef_a,
    input  logic signed [15:0] coef_b,
    input  logic signed [15:0] coef_c,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         root_count,
    input  logic signed [31:0] root_plus,
    input  logic signed [31:0] root_minus,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen
);

    qrs_pkg::res_t roots_due[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_div(longint num, longint den);
        logic   neg;
        longint un;
        longint ud;
        longint q;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        return neg ? -q : q;
    endfunction

    function automatic longint clamp32(longint r, ref logic sat);
        if (r > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic qrs_pkg::res_t solve_roots(logic signed [15:0] ca,
                                                  logic signed [15:0] cb,
                                                  logic signed [15:0] cc);
        qrs_pkg::res_t r;
        longint a;
        longint b;
        longint c;
        longint d;
        longint nb;
        longint s;
        logic   sat;
        a = ca;
        b = cb;
        c = cc;
        sat = 1'b0;
        r = '0;
        r.status = qrs_pkg::ST_OK;
        if (a == 0)
            r.status = qrs_pkg::ST_AZERO;
        else
        begin
            d = b * b - 4 * a * c;
            nb = -b * 256;
            if (d > 0)
            begin
                s = longint'(int_sqrt(64'(d) << 16));
                r.rp = 32'(clamp32(round_div((nb + s) * 128, a), sat));
                r.rm = 32'(clamp32(round_div((nb - s) * 128, a), sat));
                r.count = 2'd2;
            end
            else if (d == 0)
            begin
                r.rp = 32'(clamp32(round_div(nb * 128, a), sat));
                r.count = 2'd1;
            end
            if (sat)
                r.status = qrs_pkg::ST_SAT;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on item %0d: %s got %0d expected %0d", results_seen, what, got, want);
        fail_count++;
    endtask

    assign pending = roots_due.size();

    initial
    begin
        fail_count = 0;
        results_seen = 0;
    end

    always @(posedge clk)
    begin
        qrs_pkg::res_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                roots_due = {roots_due, solve_roots(coef_a, coef_b, coef_c)};
            if (out_valid && out_ready)
            begin
                if (roots_due.size() == 0)
                begin
                    $display("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = roots_due.pop_front();
                    if (root_count != want.count)
                        report_mismatch("root_count", root_count, want.count);
                    if (root_plus != want.rp)
                        report_mismatch("root_plus", root_plus, want.rp);
                    if (root_minus != want.rm)
                        report_mismatch("root_minus", root_minus, want.rm);
                    if (status != want.status)
                        report_mismatch("status", status, want.status);
                end
                results_seen++;
            end
        end
    end

endmodule

[tb/sv/tb_quadratic_root_solver_unit.sv]
// Testbench top for the quadratic root solver: stimulus, receiver stalls and verdict.
module tb_quadratic_root_solver_unit;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         root_count;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic [1:0]         status;
    int                 fail_count;
    int                 pending;
    int                 results_seen;
    int                 hold_cycles;
    int                 sent;

    quadratic_root_solver_unit uut (.*);

    qrs_checker chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .out_valid(out_valid), .out_ready(out_ready), .root_count(root_count),
        .root_plus(root_plus), .root_minus(root_minus), .status(status),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offer one item at a falling edge and wait for its acceptance; valid stays high
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        in_valid <= 1'b1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // mostly small-range values, which gives many real roots and exact zero discriminants
    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 1024)) - 512);
            2: return 16'($signed($urandom_range(0, 32)) - 16) << 8;
            default: return 16'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    task automatic send_random();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] k;
        a = pick_coef();
        b = pick_coef();
        if ($urandom_range(0, 5) == 0)
        begin
            // perfect square: b = 2ak, c = ak^2 so D is zero
            a = 16'($signed($urandom_range(0, 16)) - 8);
            k = 16'($signed($urandom_range(0, 16)) - 8);
            send_coefs(a, 16'(2 * $signed(a) * $signed(k)),
                       16'($signed(a) * $signed(k) * $signed(k)));
        end
        else
            send_coefs(a, b, pick_coef());
    endtask

    // receiver: random stall pattern, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        #20000000;
        $display("timeout");
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int burst;
        int gap;
        rst_n = 1'b0;
        in_valid = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        out_ready = 1'b0;
        hold_cycles = 0;
        sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: a zero, negative D, single roots, saturation, field extremes
        send_coefs(16'h0000, 16'h0100, 16'h0100);
        send_coefs(16'h0000, 16'h0000, 16'h0000);
        send_coefs(16'h0100, 16'h0000, 16'h0100);
        send_coefs(16'h0100, 16'hFE00, 16'h0100);
        send_coefs(16'h0100, 16'h0000, 16'h0000);
        send_coefs(16'h0100, 16'h0000, 16'hFF00);
        send_coefs(16'h0001, 16'h7FFF, 16'h0000);
        send_coefs(16'h0001, 16'h8000, 16'h8000);
        send_coefs(16'hFFFF, 16'h7FFF, 16'h7FFF);
        send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h8000, 16'h0000, 16'h7FFF);
        send_coefs(16'h7FFF, 16'h0001, 16'h8000);
        send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_coefs(16'h0001, 16'h0002, 16'h0001);
        send_coefs(16'h0002, 16'h0003, 16'h0001);
        send_coefs(16'hAAAA, 16'h5555, 16'h5555);
        send_coefs(16'h5555, 16'hAAAA, 16'hAAAA);

        // long receiver hold-off while items keep coming
        hold_cycles = 300;
        repeat (120) send_random();

        // pause until every outstanding item has come back
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);

        while (sent < 1820)
        begin
            burst = $urandom_range(1, 40);
            repeat (burst) send_random();
            if ($urandom_range(0, 30) == 0)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                    @(negedge clk);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("%0d coefficient sets sent, %0d root results checked", sent, results_seen);
        $display("covered a zero, negative, zero and positive discriminants, saturation");
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_queue.sv
design/qrs_back.sv
design/quadratic_root_solver_unit.sv
tb/sv/qrs_checker.sv
tb/sv/tb_quadratic_root_solver_unit.sv
